// File: rtl/core/bvo_pkg.sv
// Shared types and operation codes for the bounding volume overlap test.
`timescale 1ns / 1ps
`default_nettype none

package bvo_pkg;

    // Operation codes carried on the input transaction
    typedef enum logic [1:0] {
        OP_CIRCLE   = 2'd0,
        OP_SPHERE   = 2'd1,
        OP_CYLINDER = 2'd2
    } op_t;

    // Per-stage sideband that travels with each transaction
    typedef struct packed {
        logic valid;
        logic enable;   // low forces a miss (bad code or vertical spans apart)
    } stage_ctl_t;

endpackage : bvo_pkg

`default_nettype wire

// File: rtl/core/bvo_square.sv
// Two-stage unsigned squarer built from half-width partial products.
`timescale 1ns / 1ps
`default_nettype none

module bvo_square #(
    parameter int W = 32
) (
    input  wire             aclk,
    input  wire             en,
    input  wire  [W-1:0]    value,
    output logic [2*W-1:0]  square
);

    localparam int H = (W + 1) / 2;
    localparam int L = W - H;

    logic [H-1:0]     lo;
    logic [L-1:0]     hi;
    logic [2*H-1:0]   ll_reg;
    logic [H+L-1:0]   lh_reg;
    logic [2*L-1:0]   hh_reg;
    logic [2*W-1:0]   square_reg;
    logic [2*W-1:0]   square_next;

    assign lo = value[H-1:0];
    assign hi = value[W-1:H];

    // Stage A: form the partial products
    always_ff @(posedge aclk) begin
        if (en) begin
            ll_reg <= (2*H)'(lo) * (2*H)'(lo);
            lh_reg <= (H+L)'(lo) * (H+L)'(hi);
            hh_reg <= (2*L)'(hi) * (2*L)'(hi);
        end
    end

    // Stage B: align and add; the cross term appears twice
    always_comb begin
        square_next = {hh_reg, {(2*H){1'b0}}}
                    + ((2*W)'(lh_reg) << (H + 1))
                    + (2*W)'(ll_reg);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            square_reg <= square_next;
        end
    end

    assign square = square_reg;

endmodule : bvo_square

`default_nettype wire

// File: rtl/core/bounding_volume_overlap_test_top.sv
// Top level of the circle, sphere and upright cylinder overlap test.
//
//  channel | direction | ports                                  | handshake
//  --------+-----------+----------------------------------------+-----------------
//  s_      | in        | operation, a/b x y z radius height     | s_valid/s_ready
//  m_      | out       | hit                                    | m_valid/m_ready
//
// One transaction per cycle while the output is not stalled.
// Stages: differences and radius sum, partial products, square assembly,
// distance sum, compare. The whole pipeline advances only when the output
// register is empty or being taken, so a stall freezes every stage in place.
// Reset (aresetn low, synchronous) clears all valid bits; data is not reset.
`timescale 1ns / 1ps
`default_nettype none

module bounding_volume_overlap_test_top
    import bvo_pkg::*;
#(
    parameter int COORD_WIDTH = 32
) (
    input  wire                           aclk,
    input  wire                           aresetn,
    input  wire                           s_valid,
    output logic                          s_ready,
    input  wire        [1:0]              s_operation,
    input  wire signed [COORD_WIDTH-1:0]  s_a_x,
    input  wire signed [COORD_WIDTH-1:0]  s_a_y,
    input  wire signed [COORD_WIDTH-1:0]  s_a_z,
    input  wire        [COORD_WIDTH-2:0]  s_a_radius,
    input  wire        [COORD_WIDTH-2:0]  s_a_height,
    input  wire signed [COORD_WIDTH-1:0]  s_b_x,
    input  wire signed [COORD_WIDTH-1:0]  s_b_y,
    input  wire signed [COORD_WIDTH-1:0]  s_b_z,
    input  wire        [COORD_WIDTH-2:0]  s_b_radius,
    input  wire        [COORD_WIDTH-2:0]  s_b_height,
    output logic                          m_valid,
    input  wire                           m_ready,
    output logic                          m_hit
);

    localparam int W  = COORD_WIDTH;
    localparam int SQ = 2 * W;

    logic advance;

    // Stage 1 registers
    stage_ctl_t     ctl1_reg, ctl1_next;
    logic [W-1:0]   d1_reg, d1_next;
    logic [W-1:0]   d2_reg, d2_next;
    logic [W-1:0]   d3_reg, d3_next;
    logic [W-1:0]   rsum_reg, rsum_next;

    // Stages 2 and 3 sideband (data lives in the squarers)
    stage_ctl_t     ctl2_reg, ctl3_reg;
    logic [SQ-1:0]  sq1, sq2, sq3, rsq;

    // Stage 4 registers
    stage_ctl_t     ctl4_reg;
    logic [SQ+1:0]  dist_reg, dist_next;
    logic [SQ-1:0]  rsq_reg;

    // Stage 5 registers
    logic           valid5_reg;
    logic           hit_reg, hit_next;

    // Stage 1 helpers
    logic signed [W:0] dx, dy, dz;
    logic        [W-1:0] adx, ady, adz;
    logic signed [W:0] a_top, b_top;
    logic              span;

    // Advance the whole pipeline unless the output transaction is stalled
    assign advance = !valid5_reg || m_ready;
    assign s_ready = advance;

    // Stage 1: coordinate differences, magnitudes, radius sum, vertical span
    always_comb begin
        dx  = {s_a_x[W-1], s_a_x} - {s_b_x[W-1], s_b_x};
        dy  = {s_a_y[W-1], s_a_y} - {s_b_y[W-1], s_b_y};
        dz  = {s_a_z[W-1], s_a_z} - {s_b_z[W-1], s_b_z};
        adx = dx[W] ? W'(-dx) : dx[W-1:0];
        ady = dy[W] ? W'(-dy) : dy[W-1:0];
        adz = dz[W] ? W'(-dz) : dz[W-1:0];

        a_top = {s_a_y[W-1], s_a_y} + $signed({2'b00, s_a_height});
        b_top = {s_b_y[W-1], s_b_y} + $signed({2'b00, s_b_height});
        if (s_a_y <= s_b_y) begin
            span = a_top >= $signed({s_b_y[W-1], s_b_y});
        end else begin
            span = $signed({s_a_y[W-1], s_a_y}) <= b_top;
        end

        rsum_next = {1'b0, s_a_radius} + {1'b0, s_b_radius};
        d1_next   = adx;
        ctl1_next.valid = s_valid;
        unique case (s_operation)
            OP_CIRCLE: begin
                d2_next = ady;
                d3_next = '0;
                ctl1_next.enable = 1'b1;
            end
            OP_SPHERE: begin
                d2_next = ady;
                d3_next = adz;
                ctl1_next.enable = 1'b1;
            end
            OP_CYLINDER: begin
                d2_next = adz;
                d3_next = '0;
                ctl1_next.enable = span;
            end
            default: begin
                d2_next = '0;
                d3_next = '0;
                ctl1_next.enable = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctl1_reg <= '0;
        end else if (advance) begin
            ctl1_reg <= ctl1_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            d1_reg   <= d1_next;
            d2_reg   <= d2_next;
            d3_reg   <= d3_next;
            rsum_reg <= rsum_next;
        end
    end

    // Stages 2 and 3: square the three distances and the radius sum
    bvo_square #(.W(W)) u_sq1 (.aclk(aclk), .en(advance), .value(d1_reg),   .square(sq1));
    bvo_square #(.W(W)) u_sq2 (.aclk(aclk), .en(advance), .value(d2_reg),   .square(sq2));
    bvo_square #(.W(W)) u_sq3 (.aclk(aclk), .en(advance), .value(d3_reg),   .square(sq3));
    bvo_square #(.W(W)) u_sqr (.aclk(aclk), .en(advance), .value(rsum_reg), .square(rsq));

    // Carry the sideband alongside the squarers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctl2_reg <= '0;
            ctl3_reg <= '0;
            ctl4_reg <= '0;
        end else if (advance) begin
            ctl2_reg <= ctl1_reg;
            ctl3_reg <= ctl2_reg;
            ctl4_reg <= ctl3_reg;
        end
    end

    // Stage 4: sum the squared distances
    assign dist_next = (SQ+2)'(sq1) + (SQ+2)'(sq2) + (SQ+2)'(sq3);

    always_ff @(posedge aclk) begin
        if (advance) begin
            dist_reg <= dist_next;
            rsq_reg  <= rsq;
        end
    end

    // Stage 5: compare against the squared radius sum
    assign hit_next = ctl4_reg.enable && (dist_reg <= (SQ+2)'(rsq_reg));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid5_reg <= 1'b0;
        end else if (advance) begin
            valid5_reg <= ctl4_reg.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            hit_reg <= hit_next;
        end
    end

    assign m_valid = valid5_reg;
    assign m_hit   = hit_reg;

    // A disabled transaction (bad code or spans apart) must leave as a miss
    assert property (@(posedge aclk) disable iff (!aresetn)
        advance && ctl4_reg.valid && !ctl4_reg.enable |=> m_valid && !m_hit)
        else $error("disabled transaction produced a hit");

    // Touching volumes count as a hit
    assert property (@(posedge aclk) disable iff (!aresetn)
        advance && ctl4_reg.valid && ctl4_reg.enable
        && dist_reg == (SQ+2)'(rsq_reg) |=> m_hit)
        else $error("touching volumes not reported as a hit");

    // A stalled result holds while every stage freezes
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_hit) && $stable(ctl4_reg))
        else $error("pipeline moved during output stall");

    // Reset empties the pipeline
    assert property (@(posedge aclk)
        !aresetn |=> !m_valid && !ctl1_reg.valid && !ctl4_reg.valid)
        else $error("valid bits survived reset");

endmodule : bounding_volume_overlap_test_top

`default_nettype wire
